// ===== rtl/b64d_pkg.sv =====
// shared types, constants and the character classifier for the base64 decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    KIND_SKIP   = 2'd0,
    KIND_SEXTET = 2'd1,
    KIND_PAD    = 2'd2,
    KIND_BAD    = 2'd3
  } b64d_kind_e;

  typedef struct packed {
    b64d_kind_e kind;
    logic [5:0] sextet;
  } b64d_class_t;

  // one queue entry: the results caused by one accepted character
  typedef struct packed {
    logic [23:0] word;     // decoded group, first byte in the top bits
    logic [1:0]  num_res;  // beats to emit, 1 to 3
    logic        is_data;  // beats carry bytes
    logic        is_bad;   // single beat reporting a bad character
    logic        eom;      // final beat closes the message
  } b64d_entry_t;

  function automatic b64d_class_t b64d_classify(input logic [7:0] ch);
    b64d_class_t res;
    logic [7:0]  diff;
    res.kind   = KIND_BAD;
    res.sextet = 6'd0;
    diff       = 8'd0;
    if (ch == CH_SPACE || ch == CH_LF || ch == CH_TAB || ch == CH_CR) begin
      res.kind = KIND_SKIP;
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      diff       = ch - 8'h41;
      res.kind   = KIND_SEXTET;
      res.sextet = diff[5:0];
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      diff       = ch - 8'h61 + 8'd26;
      res.kind   = KIND_SEXTET;
      res.sextet = diff[5:0];
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      diff       = ch - 8'h30 + 8'd52;
      res.kind   = KIND_SEXTET;
      res.sextet = diff[5:0];
    end else if (ch == CH_PLUS) begin
      res.kind   = KIND_SEXTET;
      res.sextet = 6'd62;
    end else if (ch == CH_SLASH) begin
      res.kind   = KIND_SEXTET;
      res.sextet = 6'd63;
    end else if (ch == CH_PAD) begin
      res.kind   = KIND_PAD;
    end
    return res;
  endfunction

endpackage

// ===== rtl/b64d_front.sv =====
// front end: classifies characters, gathers sextets into groups, builds queue entries
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           char_code_i,
  input  logic                 message_end_i,
  output logic                 push_o,
  output b64d_pkg::b64d_entry_t entry_o
);
  import b64d_pkg::*;

  logic [17:0] buf_q, buf_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  pad_q, pad_d;
  logic        err_q, err_d;

  b64d_class_t cls;
  logic [1:0]  pad_new;
  logic [1:0]  nbytes;
  logic        has_res;

  assign cls = b64d_classify(char_code_i);

  always_comb begin
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    pad_d   = pad_q;
    err_d   = err_q;
    has_res = 1'b0;
    pad_new = pad_q;
    nbytes  = 2'd0;
    entry_o = '0;
    push_o  = 1'b0;
    if (accept_i) begin
      if (!err_q) begin
        if (cls.kind == KIND_BAD) begin
          has_res         = 1'b1;
          entry_o.is_bad  = 1'b1;
          entry_o.num_res = 2'd1;
          buf_d           = '0;
          cnt_d           = '0;
          pad_d           = '0;
          err_d           = 1'b1;
        end else if (cls.kind != KIND_SKIP) begin
          if (cls.kind == KIND_PAD && pad_q != 2'd3) begin
            pad_new = pad_q + 2'd1;
          end
          pad_d = pad_new;
          if (cnt_q != 2'd3) begin
            buf_d = {buf_q[11:0], cls.sextet};
            cnt_d = cnt_q + 2'd1;
          end else begin
            // fourth sextet closes the group, one byte dropped per pad
            nbytes       = 2'd3 - pad_new;
            entry_o.word = {buf_q, cls.sextet};
            if (nbytes != 2'd0) begin
              has_res         = 1'b1;
              entry_o.is_data = 1'b1;
              entry_o.num_res = nbytes;
            end
            buf_d = '0;
            cnt_d = '0;
            pad_d = '0;
          end
        end
      end
      if (message_end_i) begin
        entry_o.eom = 1'b1;
        if (!has_res) begin
          entry_o.num_res = 2'd1;  // bare end marker
        end
        buf_d = '0;
        cnt_d = '0;
        pad_d = '0;
        err_d = 1'b0;
      end
      push_o = has_res || message_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
      pad_q <= '0;
      err_q <= 1'b0;
    end else begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
      pad_q <= pad_d;
      err_q <= err_d;
    end
  end

endmodule

// ===== rtl/b64d_queue.sv =====
// short first-word-fall-through queue of decoded entries between front and back
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  b64d_pkg::b64d_entry_t entry_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  head_valid_o,
  output b64d_pkg::b64d_entry_t head_o
);
  import b64d_pkg::*;

  b64d_entry_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d;
  logic [QPTR_W-1:0]   rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i || pop_i;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_no_underflow;
    @(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_valid_o;
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

  property p_count_step;
    @(posedge clk_i) disable iff (!rst_ni)
      (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1;
  endproperty
  a_count_step: assert property (p_count_step) else $error("queue count slip");

endmodule

// ===== rtl/b64d_back.sv =====
// back end: expands queue entries into result beats through an output register
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  b64d_pkg::b64d_entry_t head_i,
  output logic                  pop_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [15:0]           m_tdata_o,
  output logic [1:0]            m_tuser_o,
  output logic                  m_tlast_o
);
  import b64d_pkg::*;

  logic [1:0]  idx_q, idx_d;
  logic        vld_q, vld_d;
  logic [7:0]  byte_q, byte_d;
  logic        bval_q, bval_d;
  logic        bad_q, bad_d;
  logic        eom_q, eom_d;
  logic        lir_q, lir_d;

  logic        load;
  logic        last_beat;
  logic [7:0]  sel_byte;

  assign load      = head_valid_i && (!vld_q || m_tready_i);
  assign last_beat = (idx_q == head_i.num_res - 2'd1);
  assign pop_o     = load && last_beat;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = head_i.word[23:16];
      2'd1:    sel_byte = head_i.word[15:8];
      default: sel_byte = head_i.word[7:0];
    endcase
  end

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q && !m_tready_i;
    byte_d = byte_q;
    bval_d = bval_q;
    bad_d  = bad_q;
    eom_d  = eom_q;
    lir_d  = lir_q;
    if (load) begin
      vld_d  = 1'b1;
      byte_d = head_i.is_data ? sel_byte : 8'd0;
      bval_d = head_i.is_data;
      bad_d  = head_i.is_bad;
      eom_d  = head_i.eom && last_beat;
      lir_d  = last_beat;
      idx_d  = last_beat ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    bval_q <= bval_d;
    bad_q  <= bad_d;
    eom_q  <= eom_d;
    lir_q  <= lir_d;
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = {7'd0, lir_q, byte_q};
  assign m_tuser_o  = {bad_q, bval_q};
  assign m_tlast_o  = eom_q;

  property p_num_res_nonzero;
    @(posedge clk_i) disable iff (!rst_ni) head_valid_i |-> head_i.num_res != 2'd0;
  endproperty
  a_num_res_nonzero: assert property (p_num_res_nonzero) else $error("empty entry");

  property p_idx_in_range;
    @(posedge clk_i) disable iff (!rst_ni) head_valid_i |-> idx_q < head_i.num_res;
  endproperty
  a_idx_in_range: assert property (p_idx_in_range) else $error("beat index past entry");

endmodule

// ===== rtl/base64_stream_decoder_unit.sv =====
// top level of the streaming base64 decoder: front end, entry queue, back end
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
`timescale 1ns / 1ps

// Streaming base64 decoder (standard alphabet). One character is taken per
// input beat, one character per cycle sustained; the accept side stalls only
// when the four-entry queue between the front and back end is full, which
// happens only while the output side is held off. Space, tab, CR and LF are
// skipped; '=' counts as a zero sextet and drops one trailing byte of its
// group. Every fourth sextet emits up to three byte beats, one per cycle from
// the back end unless the output side holds off. An invalid character gives
// one beat with bad_char set, then the rest of the message is ignored. The
// input beat with tlast gives at least one beat, and its final beat carries
// end_of_message (output tlast); a partial group is dropped there. The
// results of an input beat are registered in the queue, then in the output
// register. The last beat caused by one input beat has last_in_run set. No
// clearing pass is needed after reset.
module base64_stream_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tlast_i,   // message_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_byte, [8] last_in_run, rest zero
  output logic [1:0]  m_axis_tuser_o,   // [0] byte_valid, [1] bad_char
  output logic        m_axis_tlast_o    // end_of_message
);
  import b64d_pkg::*;

  logic        accept;
  logic        push;
  logic        pop;
  logic        full;
  logic        head_valid;
  b64d_entry_t entry;
  b64d_entry_t head;

  // ready depends only on queue occupancy, never on the output side directly
  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // front end: classify, collect sextets, one entry per result-producing beat
  b64d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_code_i   (s_axis_tdata_i),
    .message_end_i (s_axis_tlast_i),
    .push_o        (push),
    .entry_o       (entry)
  );

  // decouples character intake from beat output
  b64d_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back end: one result beat per cycle into the output register when not stalled
  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_o    (m_axis_tdata_o),
    .m_tuser_o    (m_axis_tuser_o),
    .m_tlast_o    (m_axis_tlast_o)
  );

  // end of message always coincides with the last beat of its run
  property p_eom_is_last;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[8];
  endproperty
  a_eom_is_last: assert property (p_eom_is_last) else $error("eom without run end");

  // a bad-character beat never carries a byte
  property p_bad_no_byte;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]);
  endproperty
  a_bad_no_byte: assert property (p_bad_no_byte) else $error("bad beat with byte");

  // a message-end beat accepted always lands in the queue
  property p_end_pushes;
    @(posedge clk_i) disable iff (!rst_ni) accept && s_axis_tlast_i |-> push;
  endproperty
  a_end_pushes: assert property (p_end_pushes) else $error("message end lost");

endmodule
